/* design/srthr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the split-tile ray hit resolver.
package srthr_pkg;

  // Default number of fraction bits in the fixed-point intercepts.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Stream widths: fields packed from bit 0 up, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 192;
  localparam int unsigned OUT_TDATA_W = 112;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned OUTCOME_W   = 2;

  // Bits of the mode selector.
  localparam int unsigned MODE_VERT_BIT = 0;
  localparam int unsigned MODE_NE_BIT   = 1;

  // Tile step direction codes.
  localparam logic [1:0] DIR_POS = 2'b01;
  localparam logic [1:0] DIR_NEG = 2'b11;

  // Resolution of one crossing.
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_PASS  = 2'd0,
    OUT_HORIZ = 2'd1,
    OUT_VERT  = 2'd2,
    OUT_MARK  = 2'd3
  } outcome_t;

  // Word leaving the decode stage.
  typedef struct packed {
    logic        vert;
    logic        ne;
    logic [1:0]  dx;
    logic [1:0]  dy;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [31:0] hxs;
    logic [31:0] hys;
    logic        fx_low;
    logic        fx_high;
    logic        fy_low;
    logic        fy_high;
    logic [33:0] sumx;
    logic [33:0] sumy;
    logic [31:0] xadv;
    logic [31:0] yadv;
    logic [11:0] spot;
  } s1_t;

  // Word leaving the decision stage.
  typedef struct packed {
    outcome_t    outcome;
    logic        move_h;
    logic        move_v;
    logic [31:0] off;
    logic [31:0] delta;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [11:0] spot;
  } s2_t;

  // Finished result word.
  typedef struct packed {
    outcome_t    outcome;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [15:0] ntx;
    logic [15:0] nty;
    logic [11:0] seen;
  } res_t;

  // Tile index of a fixed-point coordinate: arithmetic shift, low 16 bits.
  function automatic logic [15:0] tile_of(logic [31:0] v, int unsigned frac_bits);
    logic signed [31:0] sh;
    sh = $signed(v) >>> frac_bits;
    return sh[15:0];
  endfunction

endpackage

/* design/srthr_decode.sv */
`timescale 1ns / 1ps
// Stage one: unpack the input word, form half steps, fractions and sums.
module srthr_decode #(
  parameter int unsigned FRAC_BITS = srthr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [srthr_pkg::MODE_W-1:0]      in_mode,
  input  logic [srthr_pkg::IN_TDATA_W-1:0]  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output srthr_pkg::s1_t                    out_word
);
  import srthr_pkg::*;

  localparam logic [31:0] HALF = 32'd1 << (FRAC_BITS - 1);

  logic        valid_r;
  s1_t         word_r;
  s1_t         word_nxt;
  logic [31:0] step_x;
  logic [31:0] step_y;
  logic [FRAC_BITS-1:0] fx;
  logic [FRAC_BITS-1:0] fy;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  assign step_x = in_data[31:0];
  assign step_y = in_data[63:32];

  // Field split, half steps, fraction tests and the wide sums.
  always_comb begin
    word_nxt.vert = in_mode[MODE_VERT_BIT];
    word_nxt.ne   = in_mode[MODE_NE_BIT];
    word_nxt.x    = in_data[95:64];
    word_nxt.y    = in_data[127:96];
    word_nxt.tx   = in_data[143:128];
    word_nxt.ty   = in_data[159:144];
    word_nxt.dx   = in_data[161:160];
    word_nxt.dy   = in_data[163:162];
    word_nxt.spot = in_mode[MODE_VERT_BIT] ? in_data[187:176] : in_data[175:164];
    word_nxt.hxs  = {step_x[31], step_x[31:1]};
    word_nxt.hys  = {step_y[31], step_y[31:1]};
    fx = word_nxt.x[FRAC_BITS-1:0];
    fy = word_nxt.y[FRAC_BITS-1:0];
    word_nxt.fx_low  = fx < HALF[FRAC_BITS-1:0];
    word_nxt.fx_high = fx > HALF[FRAC_BITS-1:0];
    word_nxt.fy_low  = fy < HALF[FRAC_BITS-1:0];
    word_nxt.fy_high = fy > HALF[FRAC_BITS-1:0];
    word_nxt.sumx = {{(34-FRAC_BITS){1'b0}}, fx} + {{2{word_nxt.hxs[31]}}, word_nxt.hxs};
    word_nxt.sumy = {{(34-FRAC_BITS){1'b0}}, fy} + {{2{word_nxt.hys[31]}}, word_nxt.hys};
    word_nxt.xadv = word_nxt.x + word_nxt.hxs;
    word_nxt.yadv = word_nxt.y + word_nxt.hys;
  end

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

/* design/srthr_decide.sv */
`timescale 1ns / 1ps
// Stage two: classify the crossing and choose the face offset and step.
module srthr_decide #(
  parameter int unsigned FRAC_BITS = srthr_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  srthr_pkg::s1_t in_word,
  output logic           out_valid,
  input  logic           out_ready,
  output srthr_pkg::s2_t out_word
);
  import srthr_pkg::*;

  localparam logic [31:0] HALF     = 32'd1 << (FRAC_BITS - 1);
  localparam logic [31:0] NEG_HALF = 32'd0 - HALF;

  logic valid_r;
  s2_t  word_r;
  s2_t  word_nxt;
  logic lowcase;
  logic highcase;
  logic in_quarter;
  logic near_dir;
  logic far_dir;
  logic upper;
  logic plain;
  logic dx_valid;
  logic same_x_tile;
  logic same_y_tile;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  assign same_x_tile = in_word.xadv[31:FRAC_BITS] == in_word.x[31:FRAC_BITS];
  assign same_y_tile = in_word.yadv[31:FRAC_BITS] == in_word.y[31:FRAC_BITS];
  assign dx_valid    = (in_word.dx == DIR_POS) || (in_word.dx == DIR_NEG);

  // Crossing classification for both the horizontal and vertical modes.
  always_comb begin
    word_nxt.outcome = OUT_PASS;
    word_nxt.move_h  = 1'b0;
    word_nxt.move_v  = 1'b0;
    word_nxt.off     = '0;
    word_nxt.delta   = '0;
    word_nxt.x       = in_word.x;
    word_nxt.y       = in_word.y;
    word_nxt.tx      = in_word.tx;
    word_nxt.ty      = in_word.ty;
    word_nxt.spot    = in_word.spot;
    lowcase    = 1'b0;
    highcase   = 1'b0;
    in_quarter = 1'b0;
    near_dir   = 1'b0;
    far_dir    = 1'b0;
    upper      = 1'b0;
    plain      = 1'b0;
    if (!in_word.vert) begin
      lowcase  = in_word.fx_low &&
                 (in_word.ne ? (in_word.dy == DIR_POS) : (in_word.dy == DIR_NEG));
      highcase = in_word.fx_high &&
                 (in_word.ne ? (in_word.dy == DIR_NEG) : (in_word.dy == DIR_POS));
      in_quarter = lowcase ? ($signed(in_word.sumx) < $signed({2'b00, HALF}))
                           : ($signed(in_word.sumx) > $signed({2'b00, HALF}));
      near_dir = lowcase ? (in_word.dx == DIR_POS) : (in_word.dx == DIR_NEG);
      far_dir  = lowcase ? (in_word.dx == DIR_NEG) : (in_word.dx == DIR_POS);
      if (!lowcase && !highcase) begin
        // Crossing misses the diagonal half: plain horizontal face.
        word_nxt.outcome = OUT_HORIZ;
        word_nxt.move_h  = 1'b1;
      end else if (near_dir) begin
        if (in_quarter) begin
          word_nxt.outcome = OUT_HORIZ;
          word_nxt.move_h  = 1'b1;
          word_nxt.off     = (in_word.dy == DIR_POS) ? HALF : NEG_HALF;
          word_nxt.delta   = in_word.hxs;
        end else begin
          word_nxt.outcome = OUT_VERT;
          word_nxt.move_v  = 1'b1;
          word_nxt.off     = lowcase ? NEG_HALF : HALF;
          word_nxt.delta   = 32'd0 - in_word.hys;
        end
      end else if (far_dir) begin
        if (in_quarter && same_x_tile) begin
          word_nxt.outcome = OUT_HORIZ;
          word_nxt.move_h  = 1'b1;
          word_nxt.off     = (in_word.dy == DIR_POS) ? HALF : NEG_HALF;
          word_nxt.delta   = in_word.hxs;
        end
      end else begin
        word_nxt.outcome = OUT_MARK;
      end
    end else begin
      upper      = in_word.ne ? (in_word.dx == DIR_POS) : (in_word.dx == DIR_NEG);
      plain      = upper ? in_word.fy_high : in_word.fy_low;
      in_quarter = upper ? ($signed(in_word.sumy) > $signed({2'b00, HALF}))
                         : ($signed(in_word.sumy) < $signed({2'b00, HALF}));
      if (!dx_valid) begin
        word_nxt.outcome = OUT_MARK;
      end else if (plain) begin
        // Crossing misses the diagonal half: plain vertical face.
        word_nxt.outcome = OUT_VERT;
        word_nxt.move_v  = 1'b1;
      end else if (in_quarter) begin
        word_nxt.outcome = OUT_HORIZ;
        word_nxt.move_h  = 1'b1;
        word_nxt.off     = upper ? NEG_HALF : HALF;
        word_nxt.delta   = 32'd0 - in_word.hxs;
      end else if (same_y_tile) begin
        word_nxt.outcome = OUT_VERT;
        word_nxt.move_v  = 1'b1;
        word_nxt.off     = (in_word.dx == DIR_POS) ? HALF : NEG_HALF;
        word_nxt.delta   = in_word.hys;
      end
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

/* design/srthr_apply.sv */
`timescale 1ns / 1ps
// Stage three: move the intercepts onto the struck face and hold the result.
module srthr_apply #(
  parameter int unsigned FRAC_BITS = srthr_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  srthr_pkg::s2_t  in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output srthr_pkg::res_t out_word
);
  import srthr_pkg::*;

  logic        valid_r;
  res_t        word_r;
  res_t        word_nxt;
  logic [31:0] base_x;
  logic [31:0] base_y;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  // Tile corner in fixed point.
  assign base_x = {{16{in_word.tx[15]}}, in_word.tx} << FRAC_BITS;
  assign base_y = {{16{in_word.ty[15]}}, in_word.ty} << FRAC_BITS;

  // Face placement and tile recompute on the moved axis.
  always_comb begin
    word_nxt.outcome = in_word.outcome;
    word_nxt.nx      = in_word.x;
    word_nxt.ny      = in_word.y;
    word_nxt.ntx     = in_word.tx;
    word_nxt.nty     = in_word.ty;
    word_nxt.seen    = (in_word.outcome != OUT_PASS) ? in_word.spot : 12'd0;
    if (in_word.move_h) begin
      word_nxt.ny  = base_y + in_word.off;
      word_nxt.nx  = in_word.x + in_word.delta;
      word_nxt.ntx = tile_of(word_nxt.nx, FRAC_BITS);
    end else if (in_word.move_v) begin
      word_nxt.nx  = base_x + in_word.off;
      word_nxt.ny  = in_word.y + in_word.delta;
      word_nxt.nty = tile_of(word_nxt.ny, FRAC_BITS);
    end
  end

  // Output valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

/* design/split_tile_ray_hit_resolver.sv */
`timescale 1ns / 1ps
// Split-tile ray hit resolver: resolves one ray crossing of a diagonally
// split tile per word. The work is cut into three register stages (decode,
// decide, apply); a word accepted into the decode register passes on to the
// decide register and then to the apply register, whose output is the
// result. A new word is taken in every cycle while the result side
// keeps up. Each stage has its own valid bit, so a held result stalls only
// the stages behind it; empty stages keep taking words. No configuration
// and no state are kept between words.
module split_tile_ray_hit_resolver #(
  parameter int unsigned FRAC_BITS = srthr_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: step_x, step_y, intercept_x, intercept_y, tile_x,
  // tile_y, dir_x, dir_y, horiz_spot, vert_spot, zero padding.
  input  logic [srthr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Field: mode.
  input  logic [srthr_pkg::MODE_W-1:0]       in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0: new_intercept_x, new_intercept_y, new_tile_x,
  // new_tile_y, seen_index, zero padding.
  output logic [srthr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Field: outcome.
  output logic [srthr_pkg::OUTCOME_W-1:0]    out_tuser
);
  import srthr_pkg::*;

  logic s1_valid;
  logic s1_ready;
  s1_t  s1_word;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_word;
  res_t res_word;

  // Decode stage.
  srthr_decode #(
    .FRAC_BITS(FRAC_BITS)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (in_tuser),
    .in_data  (in_tdata),
    .out_valid(s1_valid),
    .out_ready(s1_ready),
    .out_word (s1_word)
  );

  // Decision stage.
  srthr_decide #(
    .FRAC_BITS(FRAC_BITS)
  ) u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_valid),
    .in_ready (s1_ready),
    .in_word  (s1_word),
    .out_valid(s2_valid),
    .out_ready(s2_ready),
    .out_word (s2_word)
  );

  // Apply stage and output register.
  srthr_apply #(
    .FRAC_BITS(FRAC_BITS)
  ) u_apply (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s2_valid),
    .in_ready (s2_ready),
    .in_word  (s2_word),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_word (res_word)
  );

  // Result word packing.
  assign out_tuser = res_word.outcome;
  assign out_tdata = {4'd0, res_word.seen, res_word.nty, res_word.ntx,
                      res_word.ny, res_word.nx};

  // An accepted word always lands in the decode stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_valid)
    else $error("accepted word did not reach the decode stage");

  // A pass-through result never sets a seen-map entry.
  a_pass_no_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res_word.outcome == OUT_PASS) |-> (res_word.seen == 12'd0))
    else $error("pass-through result carries a seen index");

  // A horizontal hit reports the tile column of its new x intercept.
  a_horiz_tile: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res_word.outcome == OUT_HORIZ) |->
      (res_word.ntx == tile_of(res_word.nx, FRAC_BITS)))
    else $error("horizontal hit tile column mismatch");

  // A vertical hit reports the tile row of its new y intercept.
  a_vert_tile: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res_word.outcome == OUT_VERT) |->
      (res_word.nty == tile_of(res_word.ny, FRAC_BITS)))
    else $error("vertical hit tile row mismatch");

endmodule

/* tb/split_tile_ray_hit_resolver_checker.sv */
`timescale 1ns / 1ps
// Checker for the split-tile ray hit resolver: predicts and compares every result word.
module split_tile_ray_hit_resolver_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  // Fields from bit 0: step_x, step_y, intercept_x, intercept_y, tile_x,
  // tile_y, dir_x, dir_y, horiz_spot, vert_spot, zero padding.
  input  logic [srthr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Field: mode.
  input  logic [srthr_pkg::MODE_W-1:0]      in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: new_intercept_x, new_intercept_y, new_tile_x,
  // new_tile_y, seen_index, zero padding.
  input  logic [srthr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Field: outcome.
  input  logic [srthr_pkg::OUTCOME_W-1:0]   out_tuser,
  output int                                fail_count,
  output int                                words_in_flight
);
  import srthr_pkg::*;

  localparam int unsigned FRAC = FRAC_BITS_DEF;

  // One ray crossing as it enters the block.
  typedef struct {
    logic [1:0]  mode;
    logic [31:0] step_x;
    logic [31:0] step_y;
    logic [31:0] ix;
    logic [31:0] iy;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [1:0]  dx;
    logic [1:0]  dy;
    logic [11:0] hspot;
    logic [11:0] vspot;
  } crossing_t;

  // Resolved crossing as it should leave the block.
  typedef struct {
    outcome_t    outcome;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [15:0] ntx;
    logic [15:0] nty;
    logic [11:0] seen;
  } resolution_t;

  resolution_t resolutions_due[$];
  resolution_t want;
  crossing_t   seen_crossing;

  // Low edge of a tile on either axis, in fixed point; wraps like a plain shifter.
  function automatic logic [31:0] base_of_tile(logic [15:0] t);
    logic [31:0] w;
    w = {{16{t[15]}}, t};
    return w << FRAC;
  endfunction

  // Whole-tile part of a coordinate, arithmetic shift.
  function automatic logic signed [31:0] coarse(logic [31:0] v);
    return $signed(v) >>> FRAC;
  endfunction

  function automatic logic [15:0] tile_of_coord(logic [31:0] v);
    logic signed [31:0] s;
    s = coarse(v);
    return s[15:0];
  endfunction

  // Decide what the ray does in the split tile and where it ends up.
  function automatic resolution_t resolve_crossing(crossing_t c);
    resolution_t r;
    logic [31:0] x, y, hxs, hys, half, frac, yoff, off, delta;
    logic [15:0] tx, ty;
    int          dx, dy, nearx;
    logic        vert, ne, low, high, lowcase, highcase, upper, plain, in_quarter;
    logic        do_h, do_v;
    longint      sum;
    outcome_t    oc;
    half  = 32'd1 << (FRAC - 1);
    hxs   = $signed(c.step_x) >>> 1;
    hys   = $signed(c.step_y) >>> 1;
    x     = c.ix;
    y     = c.iy;
    tx    = c.tx;
    ty    = c.ty;
    dx    = int'($signed(c.dx));
    dy    = int'($signed(c.dy));
    vert  = c.mode[MODE_VERT_BIT];
    ne    = c.mode[MODE_NE_BIT];
    oc    = OUT_PASS;
    do_h  = 1'b0;
    do_v  = 1'b0;
    off   = '0;
    delta = '0;

    if (!vert) begin
      // Horizontal crossing: the x fraction picks which quarter is struck.
      frac     = x & ((32'd1 << FRAC) - 1);
      low      = frac < half;
      high     = frac > half;
      lowcase  = low && (ne ? dy == 1 : dy == -1);
      highcase = high && (ne ? dy == -1 : dy == 1);
      if (!lowcase && !highcase) begin
        y  = base_of_tile(ty);
        tx = tile_of_coord(x);
        oc = OUT_HORIZ;
      end else begin
        sum        = longint'(frac) + longint'($signed(hxs));
        in_quarter = lowcase ? sum < longint'(half) : sum > longint'(half);
        nearx      = lowcase ? 1 : -1;
        yoff       = (dy == 1) ? half : -half;
        if (dx == nearx) begin
          if (in_quarter) begin
            do_h  = 1'b1;
            off   = yoff;
            delta = hxs;
          end else begin
            do_v  = 1'b1;
            off   = lowcase ? -half : half;
            delta = -hys;
          end
        end else if (dx == -nearx) begin
          // Only a hit when the ray stays in the same tile column.
          if (in_quarter && coarse(x + hxs) == coarse(x)) begin
            do_h  = 1'b1;
            off   = yoff;
            delta = hxs;
          end
        end else begin
          oc = OUT_MARK;
        end
      end
    end else if (dx != 1 && dx != -1) begin
      oc = OUT_MARK;
    end else begin
      // Vertical crossing: the y fraction picks the quarter.
      frac  = y & ((32'd1 << FRAC) - 1);
      upper = ne ? dx == 1 : dx == -1;
      plain = upper ? frac > half : frac < half;
      if (plain) begin
        x  = base_of_tile(tx);
        ty = tile_of_coord(y);
        oc = OUT_VERT;
      end else begin
        sum        = longint'(frac) + longint'($signed(hys));
        in_quarter = upper ? sum > longint'(half) : sum < longint'(half);
        if (in_quarter) begin
          do_h  = 1'b1;
          off   = upper ? -half : half;
          delta = -hxs;
        end else if (coarse(y + hys) == coarse(y)) begin
          do_v  = 1'b1;
          off   = (dx == 1) ? half : -half;
          delta = hys;
        end
      end
    end

    // Move onto the struck face and recompute the tile on the moved axis.
    if (do_h) begin
      y  = base_of_tile(ty) + off;
      x  = x + delta;
      tx = tile_of_coord(x);
      oc = OUT_HORIZ;
    end
    if (do_v) begin
      x  = base_of_tile(tx) + off;
      y  = y + delta;
      ty = tile_of_coord(y);
      oc = OUT_VERT;
    end

    r.outcome = oc;
    r.nx      = x;
    r.ny      = y;
    r.ntx     = tx;
    r.nty     = ty;
    r.seen    = (oc != OUT_PASS) ? (vert ? c.vspot : c.hspot) : 12'd0;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] expected_val, logic [31:0] actual_val);
    if (expected_val !== actual_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expected_val, actual_val);
      fail_count++;
    end
  endtask

  // Compare each result word with the oldest prediction, then record new words.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (resolutions_due.size() == 0) begin
          $error("result word arrived with no crossing waiting");
          fail_count++;
        end else begin
          want = resolutions_due.pop_front();
          check_field("outcome", 32'(want.outcome), 32'(out_tuser));
          check_field("new_intercept_x", want.nx, out_tdata[31:0]);
          check_field("new_intercept_y", want.ny, out_tdata[63:32]);
          check_field("new_tile_x", 32'(want.ntx), 32'(out_tdata[79:64]));
          check_field("new_tile_y", 32'(want.nty), 32'(out_tdata[95:80]));
          check_field("seen_index", 32'(want.seen), 32'(out_tdata[107:96]));
        end
      end
      if (in_tvalid && in_tready) begin
        seen_crossing.mode   = in_tuser;
        seen_crossing.step_x = in_tdata[31:0];
        seen_crossing.step_y = in_tdata[63:32];
        seen_crossing.ix     = in_tdata[95:64];
        seen_crossing.iy     = in_tdata[127:96];
        seen_crossing.tx     = in_tdata[143:128];
        seen_crossing.ty     = in_tdata[159:144];
        seen_crossing.dx     = in_tdata[161:160];
        seen_crossing.dy     = in_tdata[163:162];
        seen_crossing.hspot  = in_tdata[175:164];
        seen_crossing.vspot  = in_tdata[187:176];
        resolutions_due.push_back(resolve_crossing(seen_crossing));
      end
    end
    words_in_flight <= resolutions_due.size();
  end

endmodule

/* tb/split_tile_ray_hit_resolver_test.sv */
`timescale 1ns / 1ps
// Top of the resolver testbench: clock, reset, stimulus, result-side stalls and verdict.
module split_tile_ray_hit_resolver_test;
  import srthr_pkg::*;

  localparam logic [1:0] MODE_H_NWSE = 2'd0;
  localparam logic [1:0] MODE_V_NWSE = 2'd1;
  localparam logic [1:0] MODE_H_NESW = 2'd2;
  localparam logic [1:0] MODE_V_NESW = 2'd3;
  localparam logic [1:0] DIR_NONE    = 2'b00;
  localparam logic [1:0] DIR_BAD     = 2'b10;
  localparam int         CYCLE_LIMIT = 300000;
  localparam int         SEGMENT_LEN = 300;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [MODE_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUTCOME_W-1:0]   out_tuser;
  int                     fail_count;
  int                     words_in_flight;
  logic                   no_idle    = 1'b0;
  int                     stall_left = 0;
  int                     stall_draw;
  int                     cycle_count = 0;

  split_tile_ray_hit_resolver uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  split_tile_ray_hit_resolver_checker resolution_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .words_in_flight (words_in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit in case the block stops moving words.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("split_tile_ray_hit_resolver_test: FAIL");
      $finish;
    end
  end

  // Result side: after each taken word, hold off for a random stall, none in the no-idle run.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      stall_draw = no_idle ? 0 : $urandom_range(0, 19);
      stall_left <= stall_draw;
      out_tready <= (stall_draw == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offer one crossing after a random gap and hold it until it is taken.
  task automatic send_crossing(input logic [1:0] mode, input logic [31:0] sx, sy, ix, iy,
                               input logic [15:0] tx, ty, input logic [1:0] dx, dy,
                               input logic [11:0] hs, vs);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0, vs, hs, dy, dx, ty, tx, iy, ix, sy, sx};
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // Stop sending and let every outstanding word come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
  endtask

  // Mostly a real step direction, sometimes none or the unused code.
  function automatic logic [1:0] draw_direction();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 1) ? DIR_POS : DIR_NEG;
    return 2'($urandom);
  endfunction

  // Fractions cluster on and around the half-tile point where the decisions flip.
  function automatic logic [31:0] draw_intercept();
    logic [15:0] whole;
    whole = 16'($urandom);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return {whole, 16'h8000};
      2: return {whole, $urandom_range(0, 1) ? 16'h7FFF : 16'h8001};
      default: return {whole, 16'($urandom)};
    endcase
  endfunction

  // Small steps keep the ray near the quarter boundaries; some are full range.
  function automatic logic [31:0] draw_step();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 32'h30000) - 32'h18000;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All-zero words in every mode: no direction at all.
    for (int m = 0; m < 4; m++)
      send_crossing(2'(m), '0, '0, '0, '0, '0, '0, DIR_NONE, DIR_NONE, '0, '0);
    // Field extremes in both polarities.
    for (int m = 0; m < 4; m++)
      send_crossing(2'(m), 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                    16'h7FFF, 16'h8000, DIR_POS, DIR_NEG, 12'hFFF, 12'h000);
    for (int m = 0; m < 4; m++)
      send_crossing(2'(m), 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    16'h8000, 16'h7FFF, DIR_NEG, DIR_POS, 12'h000, 12'hFFF);
    // The unused direction code counts as neither step.
    send_crossing(MODE_H_NWSE, 32'h2000, 32'h2000, 32'h00011000, 32'h00011000,
                  16'h0001, 16'h0001, DIR_BAD, DIR_BAD, 12'h123, 12'h456);
    send_crossing(MODE_V_NWSE, 32'h2000, 32'h2000, 32'h00011000, 32'h00011000,
                  16'h0001, 16'h0001, DIR_BAD, DIR_BAD, 12'h123, 12'h456);
    // Fraction exactly on the half-tile point.
    send_crossing(MODE_H_NWSE, 32'h2000, 32'h2000, 32'h00018000, 32'h00020000,
                  16'h0001, 16'h0002, DIR_POS, DIR_NEG, 12'h0A5, 12'h5A0);
    send_crossing(MODE_V_NESW, 32'h2000, 32'h2000, 32'h00010000, 32'h00028000,
                  16'h0001, 16'h0002, DIR_POS, DIR_NEG, 12'h0A5, 12'h5A0);
    // Horizontal crossing: face within the quarter, the diagonal, a tile exit, same tile.
    send_crossing(MODE_H_NWSE, 32'h00002000, 32'h4000, 32'h00011000, 32'h00020000,
                  16'h0001, 16'h0002, DIR_POS, DIR_NEG, 12'h111, 12'h222);
    send_crossing(MODE_H_NWSE, 32'h00020000, 32'h4000, 32'h00011000, 32'h00020000,
                  16'h0001, 16'h0002, DIR_POS, DIR_NEG, 12'h111, 12'h222);
    send_crossing(MODE_H_NWSE, 32'hFFFFC000, 32'h4000, 32'h00011000, 32'h00020000,
                  16'h0001, 16'h0002, DIR_NEG, DIR_NEG, 12'h111, 12'h222);
    send_crossing(MODE_H_NWSE, 32'h00002000, 32'h4000, 32'h00011000, 32'h00020000,
                  16'h0001, 16'h0002, DIR_NEG, DIR_NEG, 12'h111, 12'h222);
    // Vertical crossing: inside the quarter, leaving the tile, onto the diagonal.
    send_crossing(MODE_V_NWSE, 32'h4000, 32'h00010000, 32'h00020000, 32'h00031000,
                  16'h0002, 16'h0003, DIR_NEG, DIR_POS, 12'h333, 12'h444);
    send_crossing(MODE_V_NWSE, 32'h4000, 32'hFFFFC000, 32'h00020000, 32'h00031000,
                  16'h0002, 16'h0003, DIR_NEG, DIR_POS, 12'h333, 12'h444);
    send_crossing(MODE_V_NWSE, 32'h4000, 32'h00002000, 32'h00020000, 32'h00031000,
                  16'h0002, 16'h0003, DIR_NEG, DIR_POS, 12'h333, 12'h444);
    // Sums and tile shifts that wrap around 32 bits.
    send_crossing(MODE_H_NESW, 32'h7FFFFFFE, 32'h7FFFFFFE, 32'h7FFF9000, 32'h7FFF0000,
                  16'h7FFF, 16'h7FFF, DIR_NEG, DIR_NEG, 12'hABC, 12'hCBA);
    send_crossing(MODE_V_NESW, 32'h80000000, 32'h80000000, 32'h7FFF0000, 32'h80001000,
                  16'h7FFF, 16'h8000, DIR_POS, DIR_POS, 12'hABC, 12'hCBA);
    wait_for_results();

    // Random crossings in three runs; the middle one has no idling on either side.
    for (int seg = 0; seg < 3; seg++) begin
      no_idle <= (seg == 1);
      for (int k = 0; k < SEGMENT_LEN; k++) begin
        logic [31:0] ix, iy;
        ix = draw_intercept();
        iy = draw_intercept();
        send_crossing(2'($urandom_range(0, 3)), draw_step(), draw_step(), ix, iy,
                      ($urandom_range(0, 9) < 7) ? ix[31:16] : 16'($urandom),
                      ($urandom_range(0, 9) < 7) ? iy[31:16] : 16'($urandom),
                      draw_direction(), draw_direction(), 12'($urandom), 12'($urandom));
      end
      wait_for_results();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("split_tile_ray_hit_resolver_test: PASS");
    end else begin
      $display("split_tile_ray_hit_resolver_test: FAIL");
    end
    $finish;
  end

endmodule
